[hdl/srs_pkg.sv]
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types, codes and constants of the swing ride sequencer.
// ----------------------------------------------------------------------------
package srs_pkg;

    localparam int unsigned TIME_W        = 32;
    localparam int unsigned POS_W         = 16;
    localparam int unsigned CFG_W         = 24;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned HISTORY_DEPTH = 5;

    // Ride modes
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_LOAD  = 4'd1,
        MODE_HANG  = 4'd2,
        MODE_SWING = 4'd3,
        MODE_SPIN  = 4'd4,
        MODE_BRAKE = 4'd5,
        MODE_EMERG = 4'd6,
        MODE_CATAS = 4'd7,
        MODE_LOCK  = 4'd8
    } t_mode;

    // Event codes of an input word
    typedef enum logic [1:0] {
        ACT_LOOP  = 2'd0,
        ACT_EDGE  = 2'd1,
        ACT_START = 2'd2,
        ACT_HOME  = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCKOUT   = 3'd0,
        CFG_LOAD_WAIT = 3'd1,
        CFG_PUSH      = 3'd2,
        CFG_SWING_Q   = 3'd3,
        CFG_ROTATE    = 3'd4,
        CFG_SPIN_Q    = 3'd5,
        CFG_BRAKE     = 3'd6,
        CFG_FAULT     = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_LOCKOUT   = 16'd520;
    localparam logic [15:0] RST_LOAD_WAIT = 16'd100;
    localparam logic [15:0] RST_PUSH      = 16'd1000;
    localparam logic [15:0] RST_SWING_Q   = 16'd2000;
    localparam logic [23:0] RST_ROTATE    = 24'd100000;
    localparam logic [15:0] RST_SPIN_Q    = 16'd10000;
    localparam logic [15:0] RST_BRAKE     = 16'd20000;
    localparam logic [15:0] RST_FAULT     = 16'd5000;

    localparam logic [POS_W-1:0]  HOME_POS       = 16'd6;
    localparam logic [POS_W-1:0]  HANG_POS_LIMIT = 16'd10;
    localparam logic [TIME_W-1:0] DEBOUNCE_MS    = 32'd1;
    localparam logic [TIME_W-1:0] RUN_ON_MS      = 32'd500;
    localparam logic [TIME_W-1:0] RUN_OFF_MS     = 32'd10000;
    localparam logic [TIME_W-1:0] FAULT_ON_MS    = 32'd200;
    localparam logic [TIME_W-1:0] FAULT_OFF_MS   = 32'd1000;

    // Hang oscillation: now mod 1200 compared with 600.
    // 1200 = 16 * 75, so the quotient is (now >> 4) / 75 by reciprocal.
    localparam int unsigned PHASE_PERIOD = 1200;
    localparam int unsigned PHASE_HALF   = 600;
    localparam int unsigned PHASE_SHIFT  = 4;
    localparam int unsigned PHASE_ODD    = PHASE_PERIOD >> PHASE_SHIFT;
    localparam int unsigned PHASE_X_W    = TIME_W - PHASE_SHIFT;
    localparam int unsigned RECIP_SHIFT  = PHASE_X_W + 6;
    localparam int unsigned PROD_W       = 2 * PHASE_X_W;
    localparam int unsigned QUOT_W       = PROD_W - RECIP_SHIFT;
    localparam int unsigned REM_W        = 12;
    localparam logic [PHASE_X_W-1:0] PHASE_RECIP =
        PHASE_X_W'((64'd1 << RECIP_SHIFT) / PHASE_ODD);

    typedef struct packed {
        t_action             action;
        logic [TIME_W-1:0]   now_ms;
        logic                sensor_high;
        logic                button_pressed;
    } t_item;

    typedef struct packed {
        logic [3:0]          ride_mode;
        logic                motor_enable;
        logic                motor_dir_pin;
        logic                green_led;
        logic                blink_led;
        logic [POS_W-1:0]    position;
        logic                finished_pulse;
        logic                emergency_pulse;
    } t_result;

    // Actions the sequencer asks of the datapath for one word
    typedef struct packed {
        logic start_upd;
        logic rev;
        logic lrt_edge;
        logic en_set;
        logic en_clr;
        logic pin_clr;
        logic pin_hang;
        logic green_set;
        logic green_clr;
        logic fin;
        logic emg;
    } t_ctl;

endpackage

[hdl/srs_in_if.sv]
// ----------------------------------------------------------------------------
// srs_in_if
// Event channel into the sequencer: valid/ready plus one event word.
// ----------------------------------------------------------------------------
interface srs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic        sensor_high;
    logic        button_pressed;

    modport source (
        output valid, action, now_ms, sensor_high, button_pressed,
        input  ready
    );
    modport sink (
        input  valid, action, now_ms, sensor_high, button_pressed,
        output ready
    );
endinterface

[hdl/srs_out_if.sv]
// ----------------------------------------------------------------------------
// srs_out_if
// Status channel out of the sequencer: valid/ready plus one status word.
// ----------------------------------------------------------------------------
interface srs_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  ride_mode;
    logic        motor_enable;
    logic        motor_dir_pin;
    logic        green_led;
    logic        blink_led;
    logic signed [15:0] position;
    logic        finished_pulse;
    logic        emergency_pulse;

    modport source (
        output valid, ride_mode, motor_enable, motor_dir_pin, green_led,
               blink_led, position, finished_pulse, emergency_pulse,
        input  ready
    );
    modport sink (
        input  valid, ride_mode, motor_enable, motor_dir_pin, green_led,
               blink_led, position, finished_pulse, emergency_pulse,
        output ready
    );
endinterface

[hdl/srs_core.sv]
// ----------------------------------------------------------------------------
// srs_core
// Ride state, configuration registers and the combinational update for one
// event word. Returns the status taken after the update.
// ----------------------------------------------------------------------------
module srs_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  srs_pkg::t_item                i_item,
    input  logic [srs_pkg::QUOT_W-1:0]    i_quot,
    input  logic                          i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [srs_pkg::CFG_W-1:0]     i_cfg_data,
    output srs_pkg::t_result              o_res
);
    import srs_pkg::*;

    // Configuration
    logic [15:0] r_lockout, r_load_wait, r_push, r_swing_q, r_spin_q, r_brake, r_fault;
    logic [23:0] r_rotate;

    // Ride state
    t_mode             r_mode, n_mode;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_dir_flag, n_dir_flag;
    logic              r_dir_pin, n_dir_pin;
    logic              r_en, n_en;
    logic              r_green, n_green;
    logic [TIME_W-1:0] r_last_edge, n_last_edge;
    logic [TIME_W-1:0] r_last_rev, n_last_rev;
    logic [TIME_W-1:0] r_hist [HISTORY_DEPTH];
    logic [TIME_W-1:0] n_hist [HISTORY_DEPTH];
    logic [TIME_W-1:0] r_start, n_start;
    logic              r_home_pend, n_home_pend;
    logic [TIME_W-1:0] r_home_time, n_home_time;
    logic              r_blink_on, n_blink_on;
    logic              r_blink_pin, n_blink_pin;
    logic [TIME_W-1:0] r_blink_time, n_blink_time;

    t_ctl              ctl;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] el_start, el_rev, el_home, el_blink, dif;
    logic [TIME_W-1:0] rem_full, s_sum, s_half, s_rest, rev_val;
    logic [REM_W-1:0]  rem0, rem;
    logic              hang_dir, enc_rev, rev_all;

    assign t        = i_item.now_ms;
    assign el_start = t - r_start;
    assign el_rev   = t - r_last_rev;
    assign el_home  = t - r_home_time;
    assign el_blink = t - r_blink_time;

    // now mod 1200 from the registered reciprocal quotient; one correction
    assign rem_full = t - TIME_W'(i_quot) * TIME_W'(PHASE_PERIOD);
    assign rem0     = rem_full[REM_W-1:0];
    assign rem      = (rem0 >= REM_W'(PHASE_PERIOD)) ? rem0 - REM_W'(PHASE_PERIOD) : rem0;
    assign hang_dir = (el_start < TIME_W'(r_push)) ? 1'b0 : (rem > REM_W'(PHASE_HALF));

    // Interval history shift and reversal test
    assign dif = t - r_last_edge;
    always_comb begin
        for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
            n_hist[k] = r_hist[k+1];
        end
        n_hist[HISTORY_DEPTH-1] = dif;
    end
    assign s_sum   = n_hist[0] + n_hist[1];
    assign s_half  = {s_sum[TIME_W-1], s_sum[TIME_W-1:1]};
    assign s_rest  = n_hist[2] + n_hist[3] + n_hist[4];
    assign rev_val = (s_sum << 1) + s_half - s_rest;
    assign enc_rev = (i_item.action == ACT_EDGE) && (el_rev > TIME_W'(r_lockout))
                     && rev_val[TIME_W-1];

    // Next mode and control actions
    always_comb begin
        t_mode m;
        m   = r_mode;
        ctl = '0;
        unique case (i_item.action)
            ACT_LOOP: begin
                unique case (r_mode)
                    MODE_LOAD: begin
                        if (el_start > TIME_W'(r_load_wait)) begin
                            m             = MODE_HANG;
                            ctl.en_set    = 1'b1;
                            ctl.green_clr = 1'b1;
                            ctl.start_upd = 1'b1;
                        end
                    end
                    MODE_HANG: begin
                        if ($signed(r_pos) < $signed(HANG_POS_LIMIT)) begin
                            ctl.pin_hang = 1'b1;
                        end else begin
                            m             = MODE_SWING;
                            ctl.lrt_edge  = 1'b1;
                            ctl.start_upd = 1'b1;
                        end
                    end
                    MODE_SWING: begin
                        if (el_rev > TIME_W'(r_swing_q)) m = MODE_SPIN;
                        if (el_start > TIME_W'(r_rotate)) m = MODE_BRAKE;
                    end
                    MODE_SPIN: begin
                        if (el_rev > TIME_W'(r_spin_q)) begin
                            m             = MODE_BRAKE;
                            ctl.rev       = 1'b1;
                            ctl.start_upd = 1'b1;
                        end
                    end
                    MODE_BRAKE: begin
                        if (el_start > TIME_W'(r_brake)) begin
                            m           = MODE_IDLE;
                            ctl.en_clr  = 1'b1;
                            ctl.pin_clr = 1'b1;
                            ctl.fin     = 1'b1;
                        end
                    end
                    MODE_CATAS: begin
                        if (el_start > TIME_W'(r_fault)) begin
                            m             = MODE_EMERG;
                            ctl.start_upd = 1'b1;
                        end
                    end
                    MODE_EMERG: begin
                        if (el_start > TIME_W'(r_fault)) m = MODE_LOCK;
                    end
                    MODE_LOCK: begin
                        ctl.en_clr  = 1'b1;
                        ctl.pin_clr = 1'b1;
                    end
                    default: ;
                endcase
                if (i_item.button_pressed) begin
                    unique case (m)
                        MODE_SWING: begin
                            m             = MODE_EMERG;
                            ctl.rev       = 1'b1;
                            ctl.start_upd = 1'b1;
                            ctl.emg       = 1'b1;
                        end
                        MODE_HANG, MODE_IDLE: begin
                            m       = MODE_LOCK;
                            ctl.emg = 1'b1;
                        end
                        MODE_BRAKE: begin
                            m       = MODE_EMERG;
                            ctl.emg = 1'b1;
                        end
                        MODE_SPIN: begin
                            m             = MODE_CATAS;
                            ctl.rev       = 1'b1;
                            ctl.start_upd = 1'b1;
                            ctl.emg       = 1'b1;
                        end
                        MODE_LOAD: begin
                            m             = MODE_LOCK;
                            ctl.green_clr = 1'b1;
                            ctl.emg       = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ACT_START: begin
                if (r_mode == MODE_IDLE) begin
                    m             = MODE_LOAD;
                    ctl.start_upd = 1'b1;
                    ctl.green_set = 1'b1;
                end
            end
            default: ;
        endcase
        n_mode = m;
    end

    // Datapath state
    always_comb begin
        rev_all      = ctl.rev | enc_rev;
        n_start      = ctl.start_upd ? t : r_start;
        n_dir_flag   = r_dir_flag ^ rev_all;
        n_dir_pin    = ctl.pin_hang ? hang_dir : (ctl.pin_clr ? 1'b0 : r_dir_pin ^ rev_all);
        n_en         = ctl.en_set ? 1'b1 : (ctl.en_clr ? 1'b0 : r_en);
        n_green      = ctl.green_set ? 1'b1 : (ctl.green_clr ? 1'b0 : r_green);
        n_last_rev   = enc_rev ? t : (ctl.lrt_edge ? r_last_edge : r_last_rev);
        n_last_edge  = r_last_edge;
        n_pos        = r_pos;
        n_home_pend  = r_home_pend;
        n_home_time  = r_home_time;
        n_blink_on   = r_blink_on;
        n_blink_pin  = r_blink_pin;
        n_blink_time = r_blink_time;

        case (i_item.action)
            ACT_EDGE: begin
                n_pos       = r_dir_flag ? r_pos + 1'b1 : r_pos - 1'b1;
                n_last_edge = t;
            end
            ACT_HOME: begin
                if (i_item.sensor_high) begin
                    n_home_pend = 1'b1;
                    n_home_time = t;
                end
            end
            ACT_LOOP: begin
                // debounce the home edge, then reload the position
                if (r_home_pend && el_home > DEBOUNCE_MS) begin
                    if (i_item.sensor_high) n_pos = HOME_POS;
                    n_home_pend = 1'b0;
                end
                case (n_mode) inside
                    MODE_HANG, MODE_SWING, MODE_SPIN, MODE_BRAKE,
                    MODE_LOCK, MODE_CATAS, MODE_EMERG: begin
                        if (r_blink_on) begin
                            if (el_blink > ((n_mode == MODE_LOCK || n_mode == MODE_CATAS
                                             || n_mode == MODE_EMERG) ? FAULT_ON_MS
                                                                      : RUN_ON_MS)) begin
                                n_blink_on   = 1'b0;
                                n_blink_pin  = 1'b0;
                                n_blink_time = t;
                            end
                        end else if (el_blink > ((n_mode == MODE_LOCK || n_mode == MODE_CATAS
                                                  || n_mode == MODE_EMERG) ? FAULT_OFF_MS
                                                                           : RUN_OFF_MS)) begin
                            n_blink_on   = 1'b1;
                            n_blink_pin  = 1'b1;
                            n_blink_time = t;
                        end
                    end
                    default: begin
                        n_blink_pin = 1'b0;
                        n_blink_on  = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout   <= RST_LOCKOUT;
            r_load_wait <= RST_LOAD_WAIT;
            r_push      <= RST_PUSH;
            r_swing_q   <= RST_SWING_Q;
            r_rotate    <= RST_ROTATE;
            r_spin_q    <= RST_SPIN_Q;
            r_brake     <= RST_BRAKE;
            r_fault     <= RST_FAULT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOCKOUT:   r_lockout   <= i_cfg_data[15:0];
                CFG_LOAD_WAIT: r_load_wait <= i_cfg_data[15:0];
                CFG_PUSH:      r_push      <= i_cfg_data[15:0];
                CFG_SWING_Q:   r_swing_q   <= i_cfg_data[15:0];
                CFG_ROTATE:    r_rotate    <= i_cfg_data[23:0];
                CFG_SPIN_Q:    r_spin_q    <= i_cfg_data[15:0];
                CFG_BRAKE:     r_brake     <= i_cfg_data[15:0];
                CFG_FAULT:     r_fault     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_pos        <= '0;
            r_dir_flag   <= 1'b0;
            r_dir_pin    <= 1'b0;
            r_en         <= 1'b0;
            r_green      <= 1'b0;
            r_last_edge  <= '0;
            r_last_rev   <= '0;
            r_start      <= '0;
            r_home_pend  <= 1'b0;
            r_home_time  <= '0;
            r_blink_on   <= 1'b1;
            r_blink_pin  <= 1'b0;
            r_blink_time <= '0;
            for (int k = 0; k < HISTORY_DEPTH; k++) r_hist[k] <= '0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_pos        <= n_pos;
            r_dir_flag   <= n_dir_flag;
            r_dir_pin    <= n_dir_pin;
            r_en         <= n_en;
            r_green      <= n_green;
            r_last_edge  <= n_last_edge;
            r_last_rev   <= n_last_rev;
            r_start      <= n_start;
            r_home_pend  <= n_home_pend;
            r_home_time  <= n_home_time;
            r_blink_on   <= n_blink_on;
            r_blink_pin  <= n_blink_pin;
            r_blink_time <= n_blink_time;
            if (i_item.action == ACT_EDGE) begin
                for (int k = 0; k < HISTORY_DEPTH; k++) r_hist[k] <= n_hist[k];
            end
        end
    end

    always_comb begin
        o_res.ride_mode       = n_mode;
        o_res.motor_enable    = n_en;
        o_res.motor_dir_pin   = n_dir_pin;
        o_res.green_led       = n_green;
        o_res.blink_led       = n_blink_pin;
        o_res.position        = n_pos;
        o_res.finished_pulse  = ctl.fin;
        o_res.emergency_pulse = ctl.emg;
    end

endmodule

[hdl/swing_ride_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// swing_ride_sequencer_unit
// Pendulum ride motor sequencer: event words in, one status word per event.
// ----------------------------------------------------------------------------
// Takes one event word per clock while the output is not stalled and returns
// one status word per event: the event is captured in an input register,
// then the whole ride state is updated together from it and the status
// lands in the output register. Throughput is one word per cycle while the
// output drains; a stalled output holds the input register, and the input
// side keeps accepting while the output register is free or being drained.
// Configuration writes take effect on the next clock and are meant for idle.
module swing_ride_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    srs_in_if.sink                        i_in,
    srs_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [srs_pkg::CFG_W-1:0]     i_cfg_data
);
    import srs_pkg::*;

    logic                r_in_valid;
    t_item               r_item;
    logic [QUOT_W-1:0]   r_quot;
    logic                r_out_valid;
    t_result             r_res;
    t_result             res;
    logic                step, load;
    logic [PROD_W-1:0]   prod;

    // reciprocal quotient of now / 1200, low by at most one
    assign prod = PROD_W'(i_in.now_ms[TIME_W-1:PHASE_SHIFT]) * PROD_W'(PHASE_RECIP);

    assign step       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step;
    assign load       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load)      r_in_valid <= 1'b1;
            else if (step) r_in_valid <= 1'b0;
            if (step)             r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.action         <= t_action'(i_in.action);
            r_item.now_ms         <= i_in.now_ms;
            r_item.sensor_high    <= i_in.sensor_high;
            r_item.button_pressed <= i_in.button_pressed;
            r_quot                <= prod[PROD_W-1:RECIP_SHIFT];
        end
        if (step) r_res <= res;
    end

    srs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (r_item),
        .i_quot     (r_quot),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (res)
    );

    assign o_out.valid           = r_out_valid;
    assign o_out.ride_mode       = r_res.ride_mode;
    assign o_out.motor_enable    = r_res.motor_enable;
    assign o_out.motor_dir_pin   = r_res.motor_dir_pin;
    assign o_out.green_led       = r_res.green_led;
    assign o_out.blink_led       = r_res.blink_led;
    assign o_out.position        = r_res.position;
    assign o_out.finished_pulse  = r_res.finished_pulse;
    assign o_out.emergency_pulse = r_res.emergency_pulse;

endmodule

[tb/srs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_checker
// Watches the event and status channels of the swing ride sequencer. Keeps
// its own copy of the ride state and timers, predicts the status word of
// every accepted event and compares each returned word with the oldest one.
// ----------------------------------------------------------------------------
module srs_checker
    import srs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    srs_in_if                    i_event_ch,
    srs_out_if                   i_status_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_open
);

    logic [15:0]       lockout_ms, load_wait_ms, push_ms, swing_q_ms;
    logic [15:0]       spin_q_ms, brake_ms, fault_ms;
    logic [23:0]       rotate_ms;

    t_mode             mode_q;
    logic [POS_W-1:0]  pos_q;
    logic              dir_q, pin_q, enable_q, green_q;
    logic [TIME_W-1:0] edge_t, reverse_t, mode_t, home_t, blink_t;
    logic [TIME_W-1:0] gaps [HISTORY_DEPTH];
    logic              home_pend, blink_on, blink_q;

    t_result           status_expected [$];
    int                mismatches = 0;

    function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] t_now,
                                                  input logic [TIME_W-1:0] t_mark);
        return t_now - t_mark;
    endfunction

    task automatic flip_dir();
        dir_q = !dir_q;
        pin_q = !pin_q;
    endtask

    task automatic run_blink(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] on_ms,
                             input logic [TIME_W-1:0] off_ms);
        if (blink_on) begin
            if (elapsed(t, blink_t) > on_ms) begin
                blink_on = 1'b0;
                blink_q  = 1'b0;
                blink_t  = t;
            end
        end else if (elapsed(t, blink_t) > off_ms) begin
            blink_on = 1'b1;
            blink_q  = 1'b1;
            blink_t  = t;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Advance the ride state by one event word and return its status word.
    task automatic predict_status(input t_item w, output t_result r);
        logic              fin, emg;
        logic [TIME_W-1:0] t, pair, half, rest, score;
        fin = 1'b0;
        emg = 1'b0;
        t   = w.now_ms;
        case (w.action)
            ACT_LOOP: begin
                case (mode_q)
                    MODE_LOAD: begin
                        if (elapsed(t, mode_t) > load_wait_ms) begin
                            mode_q   = MODE_HANG;
                            enable_q = 1'b1;
                            green_q  = 1'b0;
                            mode_t   = t;
                        end
                    end
                    MODE_HANG: begin
                        if ($signed(pos_q) < $signed(HANG_POS_LIMIT)) begin
                            if (elapsed(t, mode_t) < push_ms)
                                pin_q = 1'b0;
                            else
                                pin_q = (t % PHASE_PERIOD) > PHASE_HALF;
                        end else begin
                            mode_q    = MODE_SWING;
                            reverse_t = edge_t;
                            mode_t    = t;
                        end
                    end
                    MODE_SWING: begin
                        if (elapsed(t, reverse_t) > swing_q_ms)
                            mode_q = MODE_SPIN;
                        if (elapsed(t, mode_t) > rotate_ms)
                            mode_q = MODE_BRAKE;
                    end
                    MODE_SPIN: begin
                        if (elapsed(t, reverse_t) > spin_q_ms) begin
                            mode_q = MODE_BRAKE;
                            flip_dir();
                            mode_t = t;
                        end
                    end
                    MODE_BRAKE: begin
                        if (elapsed(t, mode_t) > brake_ms) begin
                            mode_q   = MODE_IDLE;
                            enable_q = 1'b0;
                            pin_q    = 1'b0;
                            fin      = 1'b1;
                        end
                    end
                    MODE_CATAS: begin
                        if (elapsed(t, mode_t) > fault_ms) begin
                            mode_q = MODE_EMERG;
                            mode_t = t;
                        end
                    end
                    MODE_EMERG: begin
                        if (elapsed(t, mode_t) > fault_ms)
                            mode_q = MODE_LOCK;
                    end
                    MODE_LOCK: begin
                        enable_q = 1'b0;
                        pin_q    = 1'b0;
                    end
                    default: ;
                endcase

                // debounce the home sensor
                if (home_pend && elapsed(t, home_t) > DEBOUNCE_MS) begin
                    if (w.sensor_high)
                        pos_q = HOME_POS;
                    home_pend = 1'b0;
                end

                if (w.button_pressed) begin
                    case (mode_q)
                        MODE_SWING: begin
                            mode_q = MODE_EMERG;
                            flip_dir();
                            mode_t = t;
                            emg    = 1'b1;
                        end
                        MODE_HANG, MODE_IDLE: begin
                            mode_q = MODE_LOCK;
                            emg    = 1'b1;
                        end
                        MODE_BRAKE: begin
                            mode_q = MODE_EMERG;
                            emg    = 1'b1;
                        end
                        MODE_SPIN: begin
                            mode_q = MODE_CATAS;
                            flip_dir();
                            mode_t = t;
                            emg    = 1'b1;
                        end
                        MODE_LOAD: begin
                            mode_q  = MODE_LOCK;
                            green_q = 1'b0;
                            emg     = 1'b1;
                        end
                        default: ;
                    endcase
                end

                if (mode_q inside {MODE_HANG, MODE_SWING, MODE_SPIN, MODE_BRAKE}) begin
                    run_blink(t, RUN_ON_MS, RUN_OFF_MS);
                end else if (mode_q inside {MODE_LOCK, MODE_CATAS, MODE_EMERG}) begin
                    run_blink(t, FAULT_ON_MS, FAULT_OFF_MS);
                end else begin
                    blink_q  = 1'b0;
                    blink_on = 1'b1;
                end
            end
            ACT_EDGE: begin
                pos_q = dir_q ? pos_q + 16'd1 : pos_q - 16'd1;
                for (int k = 0; k < HISTORY_DEPTH - 1; k++)
                    gaps[k] = gaps[k + 1];
                gaps[HISTORY_DEPTH - 1] = elapsed(t, edge_t);
                edge_t = t;
                // reverse when 5/2 of the two oldest gaps drop below the three newest
                pair  = gaps[0] + gaps[1];
                half  = {pair[TIME_W-1], pair[TIME_W-1:1]};
                rest  = gaps[2] + gaps[3] + gaps[4];
                score = (pair << 1) + half - rest;
                if (elapsed(t, reverse_t) > lockout_ms && score[TIME_W-1]) begin
                    flip_dir();
                    reverse_t = t;
                end
            end
            ACT_START: begin
                if (mode_q == MODE_IDLE) begin
                    mode_q  = MODE_LOAD;
                    mode_t  = t;
                    green_q = 1'b1;
                end
            end
            default: begin
                if (w.sensor_high) begin
                    home_pend = 1'b1;
                    home_t    = t;
                end
            end
        endcase

        r.ride_mode       = mode_q;
        r.motor_enable    = enable_q;
        r.motor_dir_pin   = pin_q;
        r.green_led       = green_q;
        r.blink_led       = blink_q;
        r.position        = pos_q;
        r.finished_pulse  = fin;
        r.emergency_pulse = emg;
    endtask

    always @(posedge i_clk) begin : watch
        t_item   word_in;
        t_result want, got;
        if (!i_rst_n) begin
            lockout_ms   = RST_LOCKOUT;
            load_wait_ms = RST_LOAD_WAIT;
            push_ms      = RST_PUSH;
            swing_q_ms   = RST_SWING_Q;
            rotate_ms    = RST_ROTATE;
            spin_q_ms    = RST_SPIN_Q;
            brake_ms     = RST_BRAKE;
            fault_ms     = RST_FAULT;
            mode_q       = MODE_IDLE;
            pos_q        = '0;
            dir_q        = 1'b0;
            pin_q        = 1'b0;
            enable_q     = 1'b0;
            green_q      = 1'b0;
            edge_t       = '0;
            reverse_t    = '0;
            mode_t       = '0;
            home_t       = '0;
            blink_t      = '0;
            home_pend    = 1'b0;
            blink_on     = 1'b1;
            blink_q      = 1'b0;
            for (int k = 0; k < HISTORY_DEPTH; k++)
                gaps[k] = '0;
            status_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LOCKOUT:   lockout_ms   = i_cfg_data[15:0];
                    CFG_LOAD_WAIT: load_wait_ms = i_cfg_data[15:0];
                    CFG_PUSH:      push_ms      = i_cfg_data[15:0];
                    CFG_SWING_Q:   swing_q_ms   = i_cfg_data[15:0];
                    CFG_ROTATE:    rotate_ms    = i_cfg_data;
                    CFG_SPIN_Q:    spin_q_ms    = i_cfg_data[15:0];
                    CFG_BRAKE:     brake_ms     = i_cfg_data[15:0];
                    CFG_FAULT:     fault_ms     = i_cfg_data[15:0];
                    default: ;
                endcase
            end

            if (i_event_ch.valid && i_event_ch.ready) begin
                word_in.action         = t_action'(i_event_ch.action);
                word_in.now_ms         = i_event_ch.now_ms;
                word_in.sensor_high    = i_event_ch.sensor_high;
                word_in.button_pressed = i_event_ch.button_pressed;
                predict_status(word_in, want);
                status_expected.push_back(want);
            end

            if (i_status_ch.valid && i_status_ch.ready) begin
                got.ride_mode       = i_status_ch.ride_mode;
                got.motor_enable    = i_status_ch.motor_enable;
                got.motor_dir_pin   = i_status_ch.motor_dir_pin;
                got.green_led       = i_status_ch.green_led;
                got.blink_led       = i_status_ch.blink_led;
                got.position        = i_status_ch.position;
                got.finished_pulse  = i_status_ch.finished_pulse;
                got.emergency_pulse = i_status_ch.emergency_pulse;
                if (status_expected.size() == 0) begin
                    $error("status word with no event pending");
                    mismatches++;
                end else begin
                    want = status_expected.pop_front();
                    check_field("ride_mode", int'(want.ride_mode), int'(got.ride_mode));
                    check_field("motor_enable", int'(want.motor_enable),
                                int'(got.motor_enable));
                    check_field("motor_dir_pin", int'(want.motor_dir_pin),
                                int'(got.motor_dir_pin));
                    check_field("green_led", int'(want.green_led), int'(got.green_led));
                    check_field("blink_led", int'(want.blink_led), int'(got.blink_led));
                    check_field("position", int'($signed(want.position)),
                                int'($signed(got.position)));
                    check_field("finished_pulse", int'(want.finished_pulse),
                                int'(got.finished_pulse));
                    check_field("emergency_pulse", int'(want.emergency_pulse),
                                int'(got.emergency_pulse));
                end
            end
        end
        o_open       <= status_expected.size();
        o_mismatches <= mismatches;
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the swing ride sequencer with directed events and random rides
// under three timer settings and three handshake idling patterns; the
// checker beside the block predicts and compares every status word.
// ----------------------------------------------------------------------------
module tb_top;
    import srs_pkg::*;

    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 260;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_TIMERS     = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    logic [TIME_W-1:0]    clock_ms;
    logic [CFG_W-1:0]     timer_set [NUM_TIMERS];
    int                   src_idle_pct;
    int                   drain_idle_pct;
    bit                   button_armed;
    logic                 hold_req;
    int                   words_sent;
    int                   quiet_cycles = 0;
    int                   mismatches;
    int                   open_words;

    srs_in_if  event_ch ();
    srs_out_if status_ch ();

    swing_ride_sequencer_unit DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (event_ch),
        .o_out      (status_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    srs_checker status_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_event_ch   (event_ch),
        .i_status_ch  (status_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_open       (open_words)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // end the run when neither channel moves a word for too long
    always @(posedge clk) begin
        if (!rst_n || (event_ch.valid && event_ch.ready) || (status_ch.valid && status_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : drain
        bit held;
        held = 1'b0;
        status_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                // hold off long enough for the event side to back up
                status_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            status_ch.ready <= ($urandom_range(0, 99) >= drain_idle_pct);
        end
    end

    task automatic send_word(input t_action act, input logic [TIME_W-1:0] t,
                             input logic sensor, input logic button);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            event_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk);
        end
        event_ch.valid          <= 1'b1;
        event_ch.action         <= act;
        event_ch.now_ms         <= t;
        event_ch.sensor_high    <= sensor;
        event_ch.button_pressed <= button;
        @(posedge clk);
        while (!event_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    // The button only matters on loop passes, and any press there ends in lockout.
    function automatic logic pick_press(input t_action act);
        if (act == ACT_LOOP)
            return button_armed && ($urandom_range(0, 19) == 0);
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic advance(input t_action act, input logic [TIME_W-1:0] dt);
        clock_ms += dt;
        send_word(act, clock_ms, $urandom_range(0, 3) != 0, pick_press(act));
    endtask

    // time step: just below, on or just past a timer, half of it, well past it, or small
    function automatic logic [TIME_W-1:0] near_timer(input t_cfg_idx idx);
        logic [TIME_W-1:0] base;
        base = TIME_W'(timer_set[idx]);
        case ($urandom_range(0, 3))
            0:       return base + $urandom_range(0, 2) - 1;
            1:       return $urandom_range(0, 50);
            2:       return base >> 1;
            default: return base + $urandom_range(2, 600);
        endcase
    endfunction

    task automatic ride_episode();
        int                kind, n;
        logic [TIME_W-1:0] gap;
        t_action           act;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            advance(ACT_START, $urandom_range(0, 20));
            n = $urandom_range(1, 3);
            repeat (n) advance(ACT_LOOP, near_timer(CFG_LOAD_WAIT));
        end else if (kind < 40) begin
            // steady edge train: position walks one way
            gap = $urandom_range(5, 300);
            n   = $urandom_range(4, 14);
            repeat (n) begin
                advance(ACT_EDGE, gap);
                if ($urandom_range(0, 1))
                    advance(ACT_LOOP, 0);
            end
        end else if (kind < 55) begin
            // two short gaps then long ones: slowing down flips the direction
            gap = $urandom_range(5, 40);
            repeat (2) advance(ACT_EDGE, gap);
            n = $urandom_range(2, 4);
            repeat (n) advance(ACT_EDGE, gap * $urandom_range(6, 12));
            advance(ACT_LOOP, 0);
        end else if (kind < 85) begin
            n = $urandom_range(1, 4);
            repeat (n) advance(ACT_LOOP, near_timer(t_cfg_idx'($urandom_range(0, 7))));
        end else if (kind < 95) begin
            advance(ACT_HOME, $urandom_range(0, 5));
            n = $urandom_range(1, 3);
            repeat (n) advance(ACT_LOOP, $urandom_range(0, 2));
        end else begin
            act = t_action'($urandom_range(0, 3));
            send_word(act, $urandom(), 1'($urandom_range(0, 1)), pick_press(act));
        end
    endtask

    task automatic run_rides(input int count);
        int target;
        target = words_sent + count;
        while (words_sent < target) ride_episode();
    endtask

    task automatic settle();
        event_ch.valid <= 1'b0;
        @(posedge clk);
        while (open_words != 0) @(posedge clk);
    endtask

    task automatic write_timers();
        cfg_we <= 1'b1;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            cfg_idx  <= t_cfg_idx'(k);
            cfg_data <= timer_set[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        event_ch.valid          <= 1'b0;
        event_ch.action         <= ACT_LOOP;
        event_ch.now_ms         <= '0;
        event_ch.sensor_high    <= 1'b0;
        event_ch.button_pressed <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_idx                 <= CFG_LOCKOUT;
        cfg_data                <= '0;
        rst_n                   <= 1'b0;
        hold_req                <= 1'b0;
        words_sent              = 0;
        button_armed            = 1'b0;
        clock_ms                = '0;
        src_idle_pct            = 29;
        drain_idle_pct          = 85;
        timer_set[CFG_LOCKOUT]   = CFG_W'(RST_LOCKOUT);
        timer_set[CFG_LOAD_WAIT] = CFG_W'(RST_LOAD_WAIT);
        timer_set[CFG_PUSH]      = CFG_W'(RST_PUSH);
        timer_set[CFG_SWING_Q]   = CFG_W'(RST_SWING_Q);
        timer_set[CFG_ROTATE]    = RST_ROTATE;
        timer_set[CFG_SPIN_Q]    = CFG_W'(RST_SPIN_Q);
        timer_set[CFG_BRAKE]     = CFG_W'(RST_BRAKE);
        timer_set[CFG_FAULT]     = CFG_W'(RST_FAULT);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed events under reset timers
        send_word(ACT_LOOP, 32'd0, 1'b0, 1'b0);
        send_word(ACT_HOME, 32'd5, 1'b0, 1'b1);     // sensor low: ignored
        send_word(ACT_HOME, 32'd10, 1'b1, 1'b0);
        send_word(ACT_LOOP, 32'd11, 1'b1, 1'b0);    // debounce not yet over
        send_word(ACT_LOOP, 32'd12, 1'b1, 1'b0);    // position homes
        send_word(ACT_HOME, 32'd20, 1'b1, 1'b0);
        send_word(ACT_LOOP, 32'd30, 1'b0, 1'b0);    // sensor dropped: pending clears
        send_word(ACT_EDGE, 32'd40, 1'b1, 1'b1);
        send_word(ACT_START, 32'd100, 1'b0, 1'b0);
        send_word(ACT_START, 32'd101, 1'b1, 1'b1);  // not idle: ignored
        send_word(ACT_LOOP, 32'd200, 1'b0, 1'b0);   // exactly the load wait: hold
        send_word(ACT_LOOP, 32'd201, 1'b0, 1'b0);
        send_word(ACT_LOOP, 32'd700, 1'b0, 1'b0);   // first push
        send_word(ACT_LOOP, 32'd1900, 1'b0, 1'b0);  // oscillation, upper half
        send_word(ACT_LOOP, 32'd2400, 1'b0, 1'b0);  // oscillation, lower half
        send_word(ACT_EDGE, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(ACT_EDGE, 32'd0, 1'b1, 1'b0);
        send_word(ACT_LOOP, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_word(ACT_EDGE, 32'd1000, 1'b0, 1'b1);  // slowdown past the lockout: reverse
        send_word(ACT_EDGE, 32'd1010, 1'b1, 1'b0);
        send_word(ACT_EDGE, 32'd1020, 1'b0, 1'b0);
        send_word(ACT_EDGE, 32'd1120, 1'b1, 1'b1);
        send_word(ACT_EDGE, 32'd1220, 1'b0, 1'b0);
        send_word(ACT_EDGE, 32'd1320, 1'b1, 1'b0);  // slowdown inside the lockout: hold
        send_word(ACT_LOOP, 32'd1330, 1'b1, 1'b0);

        // short timers, lockout off
        settle();
        for (int k = 0; k < NUM_TIMERS; k++)
            timer_set[k] = CFG_W'($urandom_range(0, 300));
        timer_set[CFG_LOCKOUT] = '0;
        write_timers();
        clock_ms = $urandom();
        run_rides(PHASE_ITEMS);

        // timers at their extremes, time stamps about to wrap
        src_idle_pct   = 85;
        drain_idle_pct = 29;
        settle();
        for (int k = 0; k < NUM_TIMERS; k++) begin
            if ($urandom_range(0, 1))
                timer_set[k] = (k == int'(CFG_ROTATE)) ? 24'hFF_FFFF : 24'h00_FFFF;
            else
                timer_set[k] = '0;
        end
        write_timers();
        clock_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
        run_rides(PHASE_ITEMS);

        // moderate timers, full rate, one long output stall, then the button
        src_idle_pct   = 0;
        drain_idle_pct = 0;
        settle();
        for (int k = 0; k < NUM_TIMERS; k++)
            timer_set[k] = CFG_W'($urandom_range(50, 3000));
        timer_set[CFG_ROTATE] = CFG_W'($urandom_range(1000, 200000));
        write_timers();
        clock_ms = $urandom();
        hold_req <= 1'b1;
        run_rides(PHASE_ITEMS / 2);
        button_armed = 1'b1;
        run_rides(PHASE_ITEMS / 2);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && open_words == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
